>>> rtl/core/box_point_classifier_top_macros.svh
// assertion macros for the box point classifier
`ifndef BOX_POINT_CLASSIFIER_TOP_MACROS_SVH
`define BOX_POINT_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bpc_pkg.sv
// shared constants and types of the box point classifier
`default_nettype none
package bpc_pkg;

  localparam int NUM_LANES   = 3;
  localparam int DIV_STEPS   = 32;
  // setup, magnitude, divider steps, saturation
  localparam int LANE_STAGES = DIV_STEPS + 3;

  localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
  localparam logic [30:0]        MAG_MAX = 31'h7fffffff;

  localparam logic [2:0] REG_CORNER_ONE_X = 3'd0;
  localparam logic [2:0] REG_CORNER_ONE_Y = 3'd1;
  localparam logic [2:0] REG_CORNER_ONE_Z = 3'd2;
  localparam logic [2:0] REG_CORNER_TWO_X = 3'd3;
  localparam logic [2:0] REG_CORNER_TWO_Y = 3'd4;
  localparam logic [2:0] REG_CORNER_TWO_Z = 3'd5;
  localparam logic [2:0] REG_UNBOUNDED    = 3'd6;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
    logic flat;
    logic contained;
  } bpc_flags_t;

  typedef struct packed {
    logic signed [31:0] norm;
    logic [30:0]        mag;
    logic               contained;
    logic               flat;
  } bpc_lane_res_t;

endpackage
`default_nettype wire

>>> rtl/core/box_point_classifier_top.sv
// top level of the box point classifier: config, lanes, flow control
//
//  channel | direction | handshake          | word
//  in      | in        | in_valid/in_stall   | point_x, point_y, point_z
//  out     | out       | out_valid/out_stall | inside_res, norm_x/y/z, box_distance, flat_axis
//  cfg     | in        | cfg_write           | cfg_index, cfg_data
//
// one point per cycle while out_stall is low; the pipeline is the 32-step
// pipelined divider in each axis lane plus setup, saturation and output stages
// reset (synchronous) empties the pipeline, corners go to 0, unbounded to 1
// a stalled output holds; stages behind it keep filling until the pipe is full
`default_nettype none
module box_point_classifier_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    inside_res,
  output logic signed [31:0]      norm_x,
  output logic signed [31:0]      norm_y,
  output logic signed [31:0]      norm_z,
  output logic [30:0]             box_distance,
  output logic                    flat_axis
);

  `include "box_point_classifier_top_macros.svh"

  localparam int NS = bpc_pkg::LANE_STAGES;

  logic signed [31:0] corner_one_x, corner_one_y, corner_one_z;
  logic signed [31:0] corner_two_x, corner_two_y, corner_two_z;
  logic               unbounded_box;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_one_x  <= 32'sd0;
      corner_one_y  <= 32'sd0;
      corner_one_z  <= 32'sd0;
      corner_two_x  <= 32'sd0;
      corner_two_y  <= 32'sd0;
      corner_two_z  <= 32'sd0;
      unbounded_box <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        bpc_pkg::REG_CORNER_ONE_X: corner_one_x  <= cfg_data;
        bpc_pkg::REG_CORNER_ONE_Y: corner_one_y  <= cfg_data;
        bpc_pkg::REG_CORNER_ONE_Z: corner_one_z  <= cfg_data;
        bpc_pkg::REG_CORNER_TWO_X: corner_two_x  <= cfg_data;
        bpc_pkg::REG_CORNER_TWO_Y: corner_two_y  <= cfg_data;
        bpc_pkg::REG_CORNER_TWO_Z: corner_two_z  <= cfg_data;
        bpc_pkg::REG_UNBOUNDED:    unbounded_box <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-stage valid bits; a stage loads when empty or when it moves on
  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  assign rdy[NS] = !out_valid || !out_stall;
  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i + 1];
  end
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i - 1];
        end
      end
      if (rdy[NS]) begin
        out_valid <= v[NS-1];
      end
    end
  end

  bpc_pkg::bpc_lane_res_t res_x, res_y, res_z;

  bpc_lane u_lane_x (
    .clk(clk), .en(rdy[NS-1:0]), .corner_a(corner_one_x), .corner_b(corner_two_x),
    .point(point_x), .res(res_x)
  );
  bpc_lane u_lane_y (
    .clk(clk), .en(rdy[NS-1:0]), .corner_a(corner_one_y), .corner_b(corner_two_y),
    .point(point_y), .res(res_y)
  );
  bpc_lane u_lane_z (
    .clk(clk), .en(rdy[NS-1:0]), .corner_a(corner_one_z), .corner_b(corner_two_z),
    .point(point_z), .res(res_z)
  );

  bpc_merge u_merge (
    .clk(clk), .en(rdy[NS]), .unbounded(unbounded_box),
    .lx(res_x), .ly(res_y), .lz(res_z),
    .inside_res(inside_res), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .box_distance(box_distance), .flat_axis(flat_axis)
  );

  logic cfg_flat;
  assign cfg_flat = (corner_one_x == corner_two_x) || (corner_one_y == corner_two_y) ||
                    (corner_one_z == corner_two_z);

  `BPC_ASSERT_NOW(a_stall_only_full, in_stall, v[0], "input stalled with empty first stage")
  `BPC_ASSERT_NOW(a_flat_matches, out_valid, flat_axis == cfg_flat, "flat flag mismatch")
  `BPC_ASSERT_NOW(a_unbounded_inside, out_valid && unbounded_box, inside_res, "unbounded not inside")
  `BPC_ASSERT_NOW(a_dist_ge_x, out_valid && !norm_x[31], box_distance >= norm_x[30:0], "distance below x")
  `BPC_ASSERT_NEXT(a_last_holds, v[NS-1] && !rdy[NS], v[NS-1], "last stage lost a word")

endmodule
`default_nettype wire

>>> rtl/core/bpc_lane.sv
// one axis lane: bounds, containment and pipelined normalising divider
`default_nettype none
module bpc_lane (
  input  wire logic                                 clk,
  input  wire logic [bpc_pkg::LANE_STAGES-1:0]      en,
  input  wire logic signed [31:0]                   corner_a,
  input  wire logic signed [31:0]                   corner_b,
  input  wire logic signed [31:0]                   point,
  output bpc_pkg::bpc_lane_res_t                    res
);

  logic signed [31:0] mn;
  logic signed [31:0] mx;
  logic [32:0]        den;
  logic               flat_c;

  assign mn     = (corner_a < corner_b) ? corner_a : corner_b;
  assign mx     = (corner_a < corner_b) ? corner_b : corner_a;
  assign den    = {mx[31], mx} - {mn[31], mn};
  assign flat_c = (den == 33'd0);

  // stage a: offset from centre, doubled
  logic [34:0] num_a;
  logic        inside_a;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_a    <= {{2{point[31]}}, point, 1'b0} - {{3{mx[31]}}, mx} - {{3{mn[31]}}, mn};
      inside_a <= (point >= mn) && (point <= mx);
    end
  end

  // stage b: magnitude and quotient overflow check
  logic [34:0] abs_b;
  logic [33:0] mag_b;
  logic        ovf_b;

  assign abs_b = num_a[34] ? (~num_a + 35'd1) : num_a;
  assign mag_b = abs_b[33:0];
  assign ovf_b = {15'd0, mag_b} >= {den, 16'd0};

  logic [49:0]         r [0:bpc_pkg::DIV_STEPS];
  logic [31:0]         q [0:bpc_pkg::DIV_STEPS];
  bpc_pkg::bpc_flags_t f [0:bpc_pkg::DIV_STEPS];

  assign q[0] = 32'd0;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r[0]           <= {mag_b, 16'd0};
      f[0].neg       <= num_a[34];
      f[0].zero      <= (num_a == 35'd0);
      f[0].ovf       <= ovf_b;
      f[0].flat      <= flat_c;
      f[0].contained <= inside_a;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < bpc_pkg::DIV_STEPS; j++) begin : g_step
    logic [63:0] dsh;
    logic [63:0] rx;
    logic [63:0] diff;
    logic        ge;

    always_comb begin
      dsh  = {31'd0, den} << (bpc_pkg::DIV_STEPS - 1 - j);
      rx   = {14'd0, r[j]};
      diff = rx - dsh;
      ge   = (rx >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en[j + 2]) begin
        r[j + 1] <= ge ? diff[49:0] : r[j];
        q[j + 1] <= {q[j][30:0], ge};
        f[j + 1] <= f[j];
      end
    end
  end

  // saturation and sign
  bpc_pkg::bpc_flags_t ff;
  logic [31:0]         qf;
  logic signed [31:0]  norm_c;
  logic [30:0]         mag_c;

  assign ff = f[bpc_pkg::DIV_STEPS];
  assign qf = q[bpc_pkg::DIV_STEPS];

  always_comb begin
    if (ff.flat && ff.zero) begin
      norm_c = 32'sd0;
      mag_c  = 31'd0;
    end else if (ff.flat || ff.ovf) begin
      norm_c = ff.neg ? bpc_pkg::Q_MIN : bpc_pkg::Q_MAX;
      mag_c  = bpc_pkg::MAG_MAX;
    end else if (!ff.neg) begin
      norm_c = qf[31] ? bpc_pkg::Q_MAX : $signed(qf);
      mag_c  = qf[31] ? bpc_pkg::MAG_MAX : qf[30:0];
    end else begin
      norm_c = (qf > 32'h80000000) ? bpc_pkg::Q_MIN : $signed(~qf + 32'd1);
      mag_c  = qf[31] ? bpc_pkg::MAG_MAX : qf[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[bpc_pkg::LANE_STAGES-1]) begin
      res.norm      <= norm_c;
      res.mag       <= mag_c;
      res.contained <= ff.contained;
      res.flat      <= ff.flat;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bpc_merge.sv
// merges the three lanes into the output word register
`default_nettype none
module bpc_merge (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic                    unbounded,
  input  wire bpc_pkg::bpc_lane_res_t  lx,
  input  wire bpc_pkg::bpc_lane_res_t  ly,
  input  wire bpc_pkg::bpc_lane_res_t  lz,
  output logic                         inside_res,
  output logic signed [31:0]           norm_x,
  output logic signed [31:0]           norm_y,
  output logic signed [31:0]           norm_z,
  output logic [30:0]                  box_distance,
  output logic                         flat_axis
);

  logic [30:0] m_xy;
  logic [30:0] m_all;

  assign m_xy  = (lx.mag > ly.mag) ? lx.mag : ly.mag;
  assign m_all = (m_xy > lz.mag) ? m_xy : lz.mag;

  always_ff @(posedge clk) begin
    if (en) begin
      inside_res   <= unbounded || (lx.contained && ly.contained && lz.contained);
      norm_x       <= lx.norm;
      norm_y       <= ly.norm;
      norm_z       <= lz.norm;
      box_distance <= m_all;
      flat_axis    <= lx.flat || ly.flat || lz.flat;
    end
  end

endmodule
`default_nettype wire
